// ===== design/oe2u_pkg.sv =====
// shared constants, types and helper functions for the escape decoder
package oe2u_pkg;

  // look-ahead window: six held bytes plus the arriving byte
  localparam int WinLen   = 7;
  localparam int HeldLen  = WinLen - 1;
  // result queue depth: one waiting result plus a full window flush
  localparam int BufDepth = WinLen + 1;

  localparam int FillW = $clog2(WinLen);
  localparam int CntW  = $clog2(BufDepth + 1);

  // character codes
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;

  // utf-8 encoding constants
  localparam logic [15:0] Utf8Lim1 = 16'h0080;
  localparam logic [15:0] Utf8Lim2 = 16'h0800;
  localparam logic [7:0]  Utf8Lead2 = 8'hC0;
  localparam logic [7:0]  Utf8Lead3 = 8'hE0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;

  typedef logic [7:0] byte_t;

  // one entry of the result queue
  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  string_end;
  } res_t;

  // true for 0-9, a-f, A-F
  function automatic logic hex_ok(input byte_t c);
    hex_ok = ((c >= ChZero) && (c <= ChNine)) ||
             ((c >= ChLowA) && (c <= ChLowF)) ||
             ((c >= ChUpA)  && (c <= ChUpF));
  endfunction

  // nibble value of a hex digit, don't care for anything else
  function automatic logic [3:0] hex_val(input byte_t c);
    byte_t t;
    t = 8'h00;
    if ((c >= ChZero) && (c <= ChNine)) begin
      t = c - ChZero;
    end else if ((c >= ChLowA) && (c <= ChLowF)) begin
      t = c - ChLowA + 8'd10;
    end else begin
      t = c - ChUpA + 8'd10;
    end
    hex_val = t[3:0];
  endfunction

endpackage

// ===== design/oe2u_in_if.sv =====
// input channel: one string byte with its final-byte flag
interface oe2u_in_if;
  logic             valid;
  logic             ready;
  oe2u_pkg::byte_t  in_byte;
  logic             in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== design/oe2u_out_if.sv =====
// output channel: one decoded byte with its run and string end flags
interface oe2u_out_if;
  logic             valid;
  logic             ready;
  oe2u_pkg::byte_t  out_byte;
  logic             run_last;
  logic             string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

// ===== design/ooxml_escape_to_utf8.sv =====
// top level of the _xHHHH_ escape to utf-8 decoder
// Decodes a byte stream in one pass: each accepted byte joins a six-byte held
// window, the seven-byte view is checked for an _xHHHH_ escape, and the bytes it
// produces (the oldest byte, the one to three utf-8 bytes of an escape, or the
// whole window flush on a final byte) are loaded into an eight-entry result queue
// in the same cycle. The queue drains one byte per cycle on the output channel
// while the output is ready, so plain text runs at one byte per cycle; an escape
// yields as many output bytes as its utf-8 length and a final byte up to seven.
// Input is taken whenever the queue holds at most one result, so a single stalled
// result does not block the input side. Results reach the output from registers.
module ooxml_escape_to_utf8 (
  input  logic              clk_i,
  input  logic              rst_ni,
  oe2u_in_if.sink           in_i,
  oe2u_out_if.source        out_o
);

  localparam int HeldLen  = oe2u_pkg::HeldLen;
  localparam int WinLen   = oe2u_pkg::WinLen;
  localparam int BufDepth = oe2u_pkg::BufDepth;
  localparam int FillW    = oe2u_pkg::FillW;
  localparam int CntW     = oe2u_pkg::CntW;

  // held window and its fill level
  oe2u_pkg::byte_t  win_q [HeldLen];
  oe2u_pkg::byte_t  win_d [HeldLen];
  logic [FillW-1:0] fill_q, fill_d;

  // result queue, head at entry zero
  oe2u_pkg::res_t   buf_q [BufDepth];
  oe2u_pkg::res_t   buf_d [BufDepth];
  logic [CntW-1:0]  cnt_q, cnt_d;

  oe2u_pkg::byte_t  cand [WinLen];
  oe2u_pkg::res_t   res  [WinLen];
  logic [FillW-1:0] res_cnt;
  logic             full, esc, push, pop;
  logic [15:0]      cp;
  logic [CntW-1:0]  base;

  assign push = in_i.valid && in_i.ready;
  assign pop  = out_o.valid && out_o.ready;

  // handshake and head of the queue
  assign in_i.ready       = (cnt_q <= CntW'(BufDepth - WinLen));
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.out_byte   = buf_q[0].data;
  assign out_o.run_last   = buf_q[0].run_last;
  assign out_o.string_end = buf_q[0].string_end;

  // seven-byte view: held bytes below the fill level, then the arriving byte
  always_comb begin
    for (int k = 0; k < HeldLen; k++) begin
      cand[k] = (FillW'(k) < fill_q) ? win_q[k] : in_i.in_byte;
    end
    cand[WinLen-1] = in_i.in_byte;
  end

  // escape match and code point
  always_comb begin
    full = (fill_q == FillW'(HeldLen));
    esc  = full && (cand[0] == oe2u_pkg::ChUnder) && (cand[1] == oe2u_pkg::ChLowX) &&
           (cand[WinLen-1] == oe2u_pkg::ChUnder) &&
           oe2u_pkg::hex_ok(cand[2]) && oe2u_pkg::hex_ok(cand[3]) &&
           oe2u_pkg::hex_ok(cand[4]) && oe2u_pkg::hex_ok(cand[5]);
    cp   = {oe2u_pkg::hex_val(cand[2]), oe2u_pkg::hex_val(cand[3]),
            oe2u_pkg::hex_val(cand[4]), oe2u_pkg::hex_val(cand[5])};
  end

  // results of this transfer, in output order
  always_comb begin
    for (int k = 0; k < WinLen; k++) begin
      res[k].data       = cand[k];
      res[k].run_last   = 1'b0;
      res[k].string_end = 1'b0;
    end
    if (esc) begin
      if (cp < oe2u_pkg::Utf8Lim1) begin
        res[0].data = cp[7:0];
        res_cnt     = FillW'(1);
      end else if (cp < oe2u_pkg::Utf8Lim2) begin
        res[0].data = oe2u_pkg::Utf8Lead2 | {3'b000, cp[10:6]};
        res[1].data = oe2u_pkg::Utf8Cont  | {2'b00, cp[5:0]};
        res_cnt     = FillW'(2);
      end else begin
        res[0].data = oe2u_pkg::Utf8Lead3 | {4'b0000, cp[15:12]};
        res[1].data = oe2u_pkg::Utf8Cont  | {2'b00, cp[11:6]};
        res[2].data = oe2u_pkg::Utf8Cont  | {2'b00, cp[5:0]};
        res_cnt     = FillW'(3);
      end
    end else if (in_i.in_last) begin
      res_cnt = fill_q + FillW'(1);
    end else if (full) begin
      res_cnt = FillW'(1);
    end else begin
      res_cnt = '0;
    end
    // flag the last result of this transfer
    for (int k = 0; k < WinLen; k++) begin
      if (FillW'(k) + FillW'(1) == res_cnt) begin
        res[k].run_last   = 1'b1;
        res[k].string_end = in_i.in_last;
      end
    end
  end

  // window update
  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (push) begin
      if (in_i.in_last || esc) begin
        fill_d = '0;
      end else if (full) begin
        for (int k = 0; k < HeldLen; k++) begin
          win_d[k] = cand[k+1];
        end
        fill_d = FillW'(HeldLen);
      end else begin
        for (int k = 0; k < HeldLen; k++) begin
          if (FillW'(k) == fill_q) begin
            win_d[k] = in_i.in_byte;
          end
        end
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  // result queue: shift out at the head, append new results behind the rest
  always_comb begin
    logic [CntW-1:0] idx;
    idx  = '0;
    base = cnt_q - CntW'(pop);
    for (int j = 0; j < BufDepth - 1; j++) begin
      buf_d[j] = pop ? buf_q[j+1] : buf_q[j];
    end
    buf_d[BufDepth-1] = buf_q[BufDepth-1];
    for (int j = 0; j < BufDepth; j++) begin
      idx = CntW'(j) - base;
      if (push && (CntW'(j) >= base) && (idx < CntW'(res_cnt))) begin
        buf_d[j] = res[idx[FillW-1:0]];
      end
    end
    cnt_d = base + (push ? CntW'(res_cnt) : CntW'(0));
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    buf_q <= buf_d;
  end

`ifndef SYNTHESIS
  // queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(BufDepth))
    else $error("result queue overflow");

  // held window never exceeds six bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FillW'(HeldLen))
    else $error("window fill out of range");

  // a final byte leaves the window empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_i.valid && in_i.ready && in_i.in_last) |=> (fill_q == '0))
    else $error("window not flushed after final byte");

  // a stalled result is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && !out_o.ready) |=> (out_o.valid &&
                   $stable(out_o.out_byte) && (cnt_q >= $past(cnt_q))))
    else $error("stalled result lost");
`endif

endmodule
